[hw/rtl/htsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsr_pkg
// shared sizes, codes and types of the handle table with swap-remove
// ----------------------------------------------------------------------------
package htsr_pkg;

  localparam int MAX_IDS       = 256;
  localparam int MAX_SLOTS     = 256;
  localparam int PAYLOAD_WIDTH = 32;

  // fixed field widths
  localparam int ID_W   = 8;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 9;
  localparam int ST_W   = 2;
  localparam int PAY_IN_W = 32;

  // free-id search: groups of GRP ids
  localparam int GRP     = 16;
  localparam int GRP_W   = $clog2(GRP);
  localparam int NGRP    = MAX_IDS / GRP;
  localparam int NGRP_W  = $clog2(NGRP);

  // input op codes
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

  // command kinds after classification
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_BADID  = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [ID_W-1:0]     entry_id;
    logic [PAY_IN_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   result_id;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   moved_id;
    logic [CNT_W-1:0]  record_count;
  } res_t;

endpackage

[hw/rtl/handle_table_swap_remove_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_table_swap_remove_unit
// handle table keeping records packed, with stable ids and swap-remove delete
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------
//  in_     | in  | in_tvalid/tready   | op in tuser, entry_id and payload
//  out_    | out | out_tvalid/tready  | status in tuser, ids, slot, count
//
// a create goes from queue head to result through a pop step and a
// three-step lowest-free-id search (group flags, group pick, bit pick)
// a delete goes through pop with map read, slot check with last-slot
// read, then the move; a delete of the last record or a rejected item ends
// earlier; the registered memory read ports set these steps
// reset clears the in-use bits, the live count and the control state; memories keep data
// the front keeps accepting into a two-entry queue while the back works or
// the output register waits, so each side stalls on its own
//
module handle_table_swap_remove_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] op
  input  logic [39:0] in_tdata,   // [7:0] entry_id, [39:8] payload

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [39:0] out_tdata   // [7:0] result_id, [15:8] slot_index,
                                  // [23:16] moved_id, [32:24] record_count
);

  logic           push;
  htsr_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_pop;
  logic           q_not_empty;
  htsr_pkg::cmd_t q_head;
  logic           res_valid;
  htsr_pkg::res_t res;
  logic           out_free;

  // output register
  logic           out_v_r, out_v_nxt;
  htsr_pkg::res_t out_r;

  htsr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser[0]),
    .in_entry_id (in_tdata[7:0]),
    .in_payload  (in_tdata[39:8]),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full)
  );

  htsr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  htsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  // the back pops only when this register is free or draining, and it
  // writes exactly one result per item, so a result never finds it full
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (res_valid) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {7'd0, out_r.record_count, out_r.moved_id,
                       out_r.slot_index, out_r.result_id};

endmodule

[hw/rtl/htsr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsr_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module htsr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htsr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output htsr_pkg::cmd_t head
);

  htsr_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/htsr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsr_front
// accepts input beats, classifies them and hands commands to the queue
// ----------------------------------------------------------------------------
module htsr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [htsr_pkg::ID_W-1:0]      in_entry_id,
  input  logic [htsr_pkg::PAY_IN_W-1:0]  in_payload,
  output logic                           push,
  output htsr_pkg::cmd_t                 push_cmd,
  input  logic                           q_full
);

  logic           hold_v_r, hold_v_nxt;
  htsr_pkg::cmd_t hold_r;
  htsr_pkg::cmd_t cls;
  logic           bad_id;

  // id zero is never handed out, ids past the table are unknown
  assign bad_id = (in_entry_id == '0) ||
                  ({1'b0, in_entry_id} >= htsr_pkg::CNT_W'(htsr_pkg::MAX_IDS));

  always_comb begin
    cls.entry_id = in_entry_id;
    cls.payload  = in_payload;
    if (in_op == htsr_pkg::OP_CREATE) begin
      cls.kind = htsr_pkg::CMD_CREATE;
    end else if (bad_id) begin
      cls.kind = htsr_pkg::CMD_BADID;
    end else begin
      cls.kind = htsr_pkg::CMD_DELETE;
    end
  end

  assign push     = hold_v_r && !q_full;
  assign push_cmd = hold_r;
  assign in_ready = !hold_v_r || !q_full;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_valid && in_ready) begin
      hold_v_nxt = 1'b1;
    end else if (push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= cls;
    end
  end

endmodule

[hw/rtl/htsr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsr_back
// executes create and delete against the id map and the dense store
// ----------------------------------------------------------------------------
module htsr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  htsr_pkg::cmd_t q_head,
  output logic           q_pop,
  input  logic           out_free,
  output logic           res_valid,
  output htsr_pkg::res_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH1 = 3'd1;
  localparam logic [2:0] S_SRCH2 = 3'd2;
  localparam logic [2:0] S_SRCH3 = 3'd3;
  localparam logic [2:0] S_DSLOT = 3'd4;
  localparam logic [2:0] S_DMOVE = 3'd5;

  logic [2:0] state_r, state_nxt;
  htsr_pkg::cmd_t cur_r;

  logic [htsr_pkg::MAX_IDS-1:0]  in_use_r, in_use_nxt;
  logic [htsr_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [htsr_pkg::NGRP-1:0]     grp_free_r, grp_free_nxt;
  logic [htsr_pkg::NGRP_W-1:0]   grp_idx_r, grp_idx_nxt;
  logic                          grp_any_r, grp_any_nxt;
  logic [htsr_pkg::SLOT_W-1:0]   slot_r, slot_nxt;

  // memories with registered read
  logic [htsr_pkg::SLOT_W-1:0]        map_mem   [htsr_pkg::MAX_IDS];
  logic [htsr_pkg::ID_W-1:0]          owner_mem [htsr_pkg::MAX_SLOTS];
  logic [htsr_pkg::PAYLOAD_WIDTH-1:0] pay_mem   [htsr_pkg::MAX_SLOTS];
  logic [htsr_pkg::SLOT_W-1:0]        map_rd_r;
  logic [htsr_pkg::ID_W-1:0]          owner_rd_r;
  logic [htsr_pkg::PAYLOAD_WIDTH-1:0] pay_rd_r;

  logic [htsr_pkg::ID_W-1:0]          map_ra;
  logic [htsr_pkg::SLOT_W-1:0]        last_ra;
  logic                               map_we, owner_we, pay_we;
  logic [htsr_pkg::ID_W-1:0]          map_wa;
  logic [htsr_pkg::SLOT_W-1:0]        map_wd;
  logic [htsr_pkg::SLOT_W-1:0]        slot_wa;
  logic [htsr_pkg::ID_W-1:0]          owner_wd;
  logic [htsr_pkg::PAYLOAD_WIDTH-1:0] pay_wd;

  logic [htsr_pkg::MAX_IDS-1:0] free_v;
  logic [htsr_pkg::GRP-1:0]     grp_bits;
  logic [htsr_pkg::GRP_W-1:0]   bit_idx;
  logic                         bit_any;
  logic [htsr_pkg::ID_W-1:0]    new_id;
  logic [htsr_pkg::CNT_W-1:0]   last;

  // id zero never counts as free
  assign free_v  = ~in_use_r & ~htsr_pkg::MAX_IDS'(1);
  assign last    = count_r - htsr_pkg::CNT_W'(1);
  assign last_ra = last[htsr_pkg::SLOT_W-1:0];
  assign map_ra  = (state_r == S_IDLE) ? q_head.entry_id : cur_r.entry_id;

  assign grp_bits = free_v[{grp_idx_r, htsr_pkg::GRP_W'(0)} +: htsr_pkg::GRP];
  always_comb begin
    bit_idx = '0;
    for (int i = htsr_pkg::GRP - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        bit_idx = htsr_pkg::GRP_W'(i);
      end
    end
  end
  assign bit_any = |grp_bits;
  assign new_id  = htsr_pkg::ID_W'({grp_idx_r, bit_idx});

  always_comb begin
    state_nxt    = state_r;
    in_use_nxt   = in_use_r;
    count_nxt    = count_r;
    grp_free_nxt = grp_free_r;
    grp_idx_nxt  = grp_idx_r;
    grp_any_nxt  = grp_any_r;
    slot_nxt     = slot_r;
    q_pop        = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    map_we       = 1'b0;
    owner_we     = 1'b0;
    pay_we       = 1'b0;
    map_wa       = cur_r.entry_id;
    map_wd       = slot_r;
    slot_wa      = slot_r;
    owner_wd     = owner_rd_r;
    pay_wd       = pay_rd_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty && out_free) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            htsr_pkg::CMD_CREATE: begin
              if (count_r == htsr_pkg::CNT_W'(htsr_pkg::MAX_SLOTS)) begin
                res_valid        = 1'b1;
                res.status       = htsr_pkg::ST_FULL;
                res.record_count = count_r;
              end else begin
                state_nxt = S_SRCH1;
              end
            end
            htsr_pkg::CMD_DELETE: begin
              if (!in_use_r[q_head.entry_id] || count_r == '0) begin
                res_valid        = 1'b1;
                res.status       = htsr_pkg::ST_UNKNOWN;
                res.result_id    = q_head.entry_id;
                res.record_count = count_r;
              end else begin
                state_nxt = S_DSLOT;
              end
            end
            default: begin
              res_valid        = 1'b1;
              res.status       = htsr_pkg::ST_UNKNOWN;
              res.result_id    = q_head.entry_id;
              res.record_count = count_r;
            end
          endcase
        end
      end
      S_SRCH1: begin
        for (int g = 0; g < htsr_pkg::NGRP; g++) begin
          grp_free_nxt[g] = |free_v[g*htsr_pkg::GRP +: htsr_pkg::GRP];
        end
        state_nxt = S_SRCH2;
      end
      S_SRCH2: begin
        grp_idx_nxt = '0;
        for (int g = htsr_pkg::NGRP - 1; g >= 0; g--) begin
          if (grp_free_r[g]) begin
            grp_idx_nxt = htsr_pkg::NGRP_W'(g);
          end
        end
        grp_any_nxt = |grp_free_r;
        state_nxt   = S_SRCH3;
      end
      S_SRCH3: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
        if (!grp_any_r || !bit_any) begin
          res.status       = htsr_pkg::ST_FULL;
          res.record_count = count_r;
        end else begin
          slot_wa            = count_r[htsr_pkg::SLOT_W-1:0];
          pay_we             = 1'b1;
          pay_wd             = cur_r.payload[htsr_pkg::PAYLOAD_WIDTH-1:0];
          owner_we           = 1'b1;
          owner_wd           = new_id;
          map_we             = 1'b1;
          map_wa             = new_id;
          map_wd             = count_r[htsr_pkg::SLOT_W-1:0];
          in_use_nxt[new_id] = 1'b1;
          count_nxt          = count_r + htsr_pkg::CNT_W'(1);
          res.status         = htsr_pkg::ST_OK;
          res.result_id      = new_id;
          res.slot_index     = count_r[htsr_pkg::SLOT_W-1:0];
          res.record_count   = count_nxt;
        end
      end
      S_DSLOT: begin
        // map_rd_r holds the slot of the id being deleted
        slot_nxt = map_rd_r;
        if ({1'b0, map_rd_r} > last) begin
          res_valid        = 1'b1;
          res.status       = htsr_pkg::ST_UNKNOWN;
          res.result_id    = cur_r.entry_id;
          res.record_count = count_r;
          state_nxt        = S_IDLE;
        end else if ({1'b0, map_rd_r} == last) begin
          // last record goes, nothing moves
          in_use_nxt[cur_r.entry_id] = 1'b0;
          count_nxt        = last;
          res_valid        = 1'b1;
          res.status       = htsr_pkg::ST_OK;
          res.result_id    = cur_r.entry_id;
          res.slot_index   = map_rd_r;
          res.record_count = last;
          state_nxt        = S_IDLE;
        end else begin
          state_nxt = S_DMOVE;
        end
      end
      S_DMOVE: begin
        // owner and payload of the last slot are in the read registers
        pay_we   = 1'b1;
        owner_we = 1'b1;
        map_we   = ({1'b0, owner_rd_r} < htsr_pkg::CNT_W'(htsr_pkg::MAX_IDS));
        map_wa   = owner_rd_r;
        map_wd   = slot_r;
        in_use_nxt[cur_r.entry_id] = 1'b0;
        count_nxt        = last;
        res_valid        = 1'b1;
        res.status       = htsr_pkg::ST_OK;
        res.result_id    = cur_r.entry_id;
        res.slot_index   = slot_r;
        res.moved_id     = owner_rd_r;
        res.record_count = last;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_use_r <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_free_r <= grp_free_nxt;
    grp_idx_r  <= grp_idx_nxt;
    grp_any_r  <= grp_any_nxt;
    slot_r     <= slot_nxt;
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_r <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[slot_wa] <= owner_wd;
    end
    owner_rd_r <= owner_mem[last_ra];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[slot_wa] <= pay_wd;
    end
    pay_rd_r <= pay_mem[last_ra];
  end

endmodule
